[hw/rtl/mrdp_pkg.sv]
// Types and constants shared by the move record delta packer.
package mrdp_pkg;

  localparam int ANG_W      = 16;
  localparam int POS_W      = 6;
  localparam int TRIG_IN_W  = 6;
  localparam int VAL_W      = 16;
  localparam int LEN_W      = 5;
  localparam int NULL_POS   = 16;
  localparam int QUEUE_DEPTH = 2;

  // Chunk slots in stream order; trigger bits follow from SLOT_TRIG_0 on.
  localparam int SLOT_ANY     = 0;
  localparam int SLOT_YAW_F   = 1;
  localparam int SLOT_YAW_V   = 2;
  localparam int SLOT_PITCH_F = 3;
  localparam int SLOT_PITCH_V = 4;
  localparam int SLOT_ROLL_F  = 5;
  localparam int SLOT_ROLL_V  = 6;
  localparam int SLOT_X_F     = 7;
  localparam int SLOT_X_V     = 8;
  localparam int SLOT_Y_F     = 9;
  localparam int SLOT_Y_V     = 10;
  localparam int SLOT_Z_F     = 11;
  localparam int SLOT_Z_V     = 12;
  localparam int SLOT_FL      = 13;
  localparam int SLOT_KB      = 14;
  localparam int SLOT_TRIG_F  = 15;
  localparam int SLOT_TRIG_0  = 16;

  typedef struct packed {
    logic                 use_base;
    logic [ANG_W-1:0]     yaw_code;
    logic [ANG_W-1:0]     pitch_code;
    logic [ANG_W-1:0]     roll_code;
    logic [POS_W-1:0]     pos_x_code;
    logic [POS_W-1:0]     pos_y_code;
    logic [POS_W-1:0]     pos_z_code;
    logic                 free_look;
    logic                 keyboard_mouse;
    logic [TRIG_IN_W-1:0] trigger_bits;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] chunk_value;
    logic [LEN_W-1:0] chunk_length;
    logic             last_chunk;
  } out_t;

  // Classified record handed from the front to the back.
  typedef struct packed {
    logic                 any_en;
    logic                 any;
    logic                 body;
    logic                 yaw_d;
    logic                 pitch_d;
    logic                 roll_d;
    logic                 x_d;
    logic                 y_d;
    logic                 z_d;
    logic                 trig_d;
    logic [ANG_W-1:0]     yaw;
    logic [ANG_W-1:0]     pitch;
    logic [ANG_W-1:0]     roll;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [POS_W-1:0]     pos_z;
    logic                 free_look;
    logic                 keyboard_mouse;
    logic [TRIG_IN_W-1:0] trig;
  } cls_t;

endpackage

[hw/rtl/move_record_delta_packer_top.sv]
// Top level of the move record delta packer.
//
// Input channel (in_valid, in_stall, in_data): one beat is one quantized move
// record plus use_base, which picks the stored previous record or the null
// record as the base. Result channel (out_valid, out_stall, out_data): one
// beat is one bit-chunk, right aligned, with its length; last_chunk marks the
// final chunk of a record. A record yields 1 to 16 + TRIGGER_COUNT chunks.
// A taken record is written into the queue, and its first chunk then into the
// output register of the back end. The back end sends one chunk per cycle
// while the result channel does not stall; its chunk sequencer walks the
// slots of each record. The front end classifies a
// record in the cycle it is taken and puts it into a two-entry queue, so new
// records are taken while earlier ones still drain.
// Reset (synchronous, rst_n low) empties the queue, drops any chunk on the
// result channel and loads the null record as base: angles zero, positions
// 16, flags and triggers zero. A stall on the result channel holds the chunk
// in place; once the queue fills, in_stall rises and holds the input.
module move_record_delta_packer_top #(
  parameter int TRIGGER_COUNT = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mrdp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output mrdp_pkg::out_t out_data
);

  logic           push, pop, q_full, head_valid;
  mrdp_pkg::cls_t push_data, head_data;

  // Hold the input only while the queue has no room.
  assign in_stall = q_full;

  mrdp_front #(
    .TRIGGER_COUNT(TRIGGER_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  mrdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_data (head_data)
  );

  mrdp_back #(
    .TRIGGER_COUNT(TRIGGER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_data (head_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/mrdp_front.sv]
// Front end: accepts records, compares them with the base and updates the base.
module mrdp_front #(
  parameter int TRIGGER_COUNT = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  mrdp_pkg::in_t    in_data,
  input  logic             q_full,
  output logic             push,
  output mrdp_pkg::cls_t   push_data
);

  localparam int TW = mrdp_pkg::TRIG_IN_W;
  localparam logic [TW-1:0] TRIG_MASK =
    (TRIGGER_COUNT >= TW) ? {TW{1'b1}} : TW'((1 << TRIGGER_COUNT) - 1);
  localparam logic [mrdp_pkg::POS_W-1:0] NULL_POS =
    mrdp_pkg::POS_W'(mrdp_pkg::NULL_POS);

  logic [mrdp_pkg::ANG_W-1:0] b_yaw_r, b_pitch_r, b_roll_r;
  logic [mrdp_pkg::POS_W-1:0] b_x_r, b_y_r, b_z_r;
  logic                       b_fl_r, b_kb_r;
  logic [TW-1:0]              b_trig_r;

  logic [mrdp_pkg::ANG_W-1:0] r_yaw, r_pitch, r_roll;
  logic [mrdp_pkg::POS_W-1:0] r_x, r_y, r_z;
  logic                       r_fl, r_kb;
  logic [TW-1:0]              r_trig;
  logic [TW-1:0]              trig;

  assign push = in_valid && !q_full;
  assign trig = in_data.trigger_bits & TRIG_MASK;

  always_comb begin
    if (in_data.use_base) begin
      r_yaw   = b_yaw_r;
      r_pitch = b_pitch_r;
      r_roll  = b_roll_r;
      r_x     = b_x_r;
      r_y     = b_y_r;
      r_z     = b_z_r;
      r_fl    = b_fl_r;
      r_kb    = b_kb_r;
      r_trig  = b_trig_r;
    end else begin
      r_yaw   = '0;
      r_pitch = '0;
      r_roll  = '0;
      r_x     = NULL_POS;
      r_y     = NULL_POS;
      r_z     = NULL_POS;
      r_fl    = 1'b0;
      r_kb    = 1'b0;
      r_trig  = '0;
    end
  end

  always_comb begin
    push_data.yaw_d          = in_data.yaw_code != r_yaw;
    push_data.pitch_d        = in_data.pitch_code != r_pitch;
    push_data.roll_d         = in_data.roll_code != r_roll;
    push_data.x_d            = in_data.pos_x_code != r_x;
    push_data.y_d            = in_data.pos_y_code != r_y;
    push_data.z_d            = in_data.pos_z_code != r_z;
    push_data.trig_d         = trig != r_trig;
    push_data.any            = push_data.yaw_d || push_data.pitch_d || push_data.roll_d ||
                               push_data.x_d || push_data.y_d || push_data.z_d ||
                               push_data.trig_d || (in_data.free_look != r_fl) ||
                               (in_data.keyboard_mouse != r_kb);
    push_data.any_en         = !in_data.use_base;
    push_data.body           = in_data.use_base || push_data.any;
    push_data.yaw            = in_data.yaw_code;
    push_data.pitch          = in_data.pitch_code;
    push_data.roll           = in_data.roll_code;
    push_data.pos_x          = in_data.pos_x_code;
    push_data.pos_y          = in_data.pos_y_code;
    push_data.pos_z          = in_data.pos_z_code;
    push_data.free_look      = in_data.free_look;
    push_data.keyboard_mouse = in_data.keyboard_mouse;
    push_data.trig           = trig;
  end

  // Take the accepted record as the new base.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_yaw_r   <= '0;
      b_pitch_r <= '0;
      b_roll_r  <= '0;
      b_x_r     <= NULL_POS;
      b_y_r     <= NULL_POS;
      b_z_r     <= NULL_POS;
      b_fl_r    <= 1'b0;
      b_kb_r    <= 1'b0;
      b_trig_r  <= '0;
    end else if (push) begin
      b_yaw_r   <= in_data.yaw_code;
      b_pitch_r <= in_data.pitch_code;
      b_roll_r  <= in_data.roll_code;
      b_x_r     <= in_data.pos_x_code;
      b_y_r     <= in_data.pos_y_code;
      b_z_r     <= in_data.pos_z_code;
      b_fl_r    <= in_data.free_look;
      b_kb_r    <= in_data.keyboard_mouse;
      b_trig_r  <= trig;
    end
  end

endmodule

[hw/rtl/mrdp_queue.sv]
// Short queue of classified records between front and back.
module mrdp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mrdp_pkg::cls_t  push_data,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output mrdp_pkg::cls_t  head_data
);

  localparam int DEPTH = mrdp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mrdp_pkg::cls_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_data  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("push into full queue");

endmodule

[hw/rtl/mrdp_back.sv]
// Back end: walks the chunk slots of the head record and drives the output register.
module mrdp_back #(
  parameter int TRIGGER_COUNT = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  mrdp_pkg::cls_t  head_data,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output mrdp_pkg::out_t  out_data
);

  localparam int NSLOT  = mrdp_pkg::SLOT_TRIG_0 + TRIGGER_COUNT;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int TW     = mrdp_pkg::TRIG_IN_W;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NSLOT - 1);

  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   cur, nxt_slot, tidx;
  logic                out_valid_r, out_valid_nxt;
  mrdp_pkg::out_t      out_r;
  mrdp_pkg::out_t      chunk;
  logic                load, last;
  logic [7:0]          trig_pad;

  // Slot zero carries the any-change flag: skip it when no any-change flag goes out.
  assign cur      = (slot_r == '0 && !head_data.any_en) ?
                    SLOT_W'(mrdp_pkg::SLOT_YAW_F) : slot_r;
  assign tidx     = cur - SLOT_W'(mrdp_pkg::SLOT_TRIG_0);
  assign trig_pad = 8'(head_data.trig);

  always_comb begin
    unique case (cur)
      SLOT_W'(mrdp_pkg::SLOT_YAW_F):   nxt_slot = head_data.yaw_d   ? cur + 1'b1 : cur + 2'd2;
      SLOT_W'(mrdp_pkg::SLOT_PITCH_F): nxt_slot = head_data.pitch_d ? cur + 1'b1 : cur + 2'd2;
      SLOT_W'(mrdp_pkg::SLOT_ROLL_F):  nxt_slot = head_data.roll_d  ? cur + 1'b1 : cur + 2'd2;
      SLOT_W'(mrdp_pkg::SLOT_X_F):     nxt_slot = head_data.x_d     ? cur + 1'b1 : cur + 2'd2;
      SLOT_W'(mrdp_pkg::SLOT_Y_F):     nxt_slot = head_data.y_d     ? cur + 1'b1 : cur + 2'd2;
      SLOT_W'(mrdp_pkg::SLOT_Z_F):     nxt_slot = head_data.z_d     ? cur + 1'b1 : cur + 2'd2;
      default:                         nxt_slot = cur + 1'b1;
    endcase
  end

  assign last = (cur == SLOT_W'(mrdp_pkg::SLOT_ANY) && !head_data.body) ||
                (cur == SLOT_W'(mrdp_pkg::SLOT_TRIG_F) && !head_data.trig_d) ||
                (cur == SLOT_LAST);

  always_comb begin
    chunk.last_chunk   = last;
    chunk.chunk_length = mrdp_pkg::LEN_W'(1);
    unique case (cur)
      SLOT_W'(mrdp_pkg::SLOT_ANY):     chunk.chunk_value = 16'(head_data.any);
      SLOT_W'(mrdp_pkg::SLOT_YAW_F):   chunk.chunk_value = 16'(head_data.yaw_d);
      SLOT_W'(mrdp_pkg::SLOT_PITCH_F): chunk.chunk_value = 16'(head_data.pitch_d);
      SLOT_W'(mrdp_pkg::SLOT_ROLL_F):  chunk.chunk_value = 16'(head_data.roll_d);
      SLOT_W'(mrdp_pkg::SLOT_X_F):     chunk.chunk_value = 16'(head_data.x_d);
      SLOT_W'(mrdp_pkg::SLOT_Y_F):     chunk.chunk_value = 16'(head_data.y_d);
      SLOT_W'(mrdp_pkg::SLOT_Z_F):     chunk.chunk_value = 16'(head_data.z_d);
      SLOT_W'(mrdp_pkg::SLOT_FL):      chunk.chunk_value = 16'(head_data.free_look);
      SLOT_W'(mrdp_pkg::SLOT_KB):      chunk.chunk_value = 16'(head_data.keyboard_mouse);
      SLOT_W'(mrdp_pkg::SLOT_TRIG_F):  chunk.chunk_value = 16'(head_data.trig_d);
      SLOT_W'(mrdp_pkg::SLOT_YAW_V): begin
        chunk.chunk_value  = head_data.yaw;
        chunk.chunk_length = mrdp_pkg::LEN_W'(mrdp_pkg::ANG_W);
      end
      SLOT_W'(mrdp_pkg::SLOT_PITCH_V): begin
        chunk.chunk_value  = head_data.pitch;
        chunk.chunk_length = mrdp_pkg::LEN_W'(mrdp_pkg::ANG_W);
      end
      SLOT_W'(mrdp_pkg::SLOT_ROLL_V): begin
        chunk.chunk_value  = head_data.roll;
        chunk.chunk_length = mrdp_pkg::LEN_W'(mrdp_pkg::ANG_W);
      end
      SLOT_W'(mrdp_pkg::SLOT_X_V): begin
        chunk.chunk_value  = 16'(head_data.pos_x);
        chunk.chunk_length = mrdp_pkg::LEN_W'(mrdp_pkg::POS_W);
      end
      SLOT_W'(mrdp_pkg::SLOT_Y_V): begin
        chunk.chunk_value  = 16'(head_data.pos_y);
        chunk.chunk_length = mrdp_pkg::LEN_W'(mrdp_pkg::POS_W);
      end
      SLOT_W'(mrdp_pkg::SLOT_Z_V): begin
        chunk.chunk_value  = 16'(head_data.pos_z);
        chunk.chunk_length = mrdp_pkg::LEN_W'(mrdp_pkg::POS_W);
      end
      // trigger bits; those past the input width read as zero
      default: chunk.chunk_value =
        16'((tidx < SLOT_W'(TW)) ? trig_pad[tidx[2:0]] : 1'b0);
    endcase
  end

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && last;

  always_comb begin
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      slot_nxt      = last ? '0 : nxt_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= chunk;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n) slot_r <= SLOT_LAST)
    else $error("chunk slot past the last trigger bit");
  assert property (@(posedge clk) disable iff (!rst_n)
                   load && last |=> slot_r == '0)
    else $error("slot not rewound after last chunk");
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && out_r.last_chunk |-> out_r.chunk_length == mrdp_pkg::LEN_W'(1))
    else $error("record ends on a value chunk");

endmodule

[sim/move_record_delta_packer_top_tb.sv]
// Self-checking testbench for the move record delta packer top level.
module move_record_delta_packer_top_tb;

  localparam int ANG_W       = mrdp_pkg::ANG_W;
  localparam int POS_W       = mrdp_pkg::POS_W;
  localparam int VAL_W       = mrdp_pkg::VAL_W;
  localparam int LEN_W       = mrdp_pkg::LEN_W;
  localparam int TRIG_IN_W   = mrdp_pkg::TRIG_IN_W;
  localparam logic [POS_W-1:0] NULL_POS = POS_W'(mrdp_pkg::NULL_POS);
  localparam int TRIG_CNT    = 6;
  localparam int MAX_CHUNKS  = 16 + TRIG_CNT;
  localparam int FLAG_LEN    = 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 8;
  localparam logic [25:0] NULL_OTHER = {8'd0, NULL_POS, NULL_POS, NULL_POS};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mrdp_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mrdp_pkg::out_t out_data;

  // Predictor copy of the stored base record.
  logic [3*ANG_W-1:0] stored_angles = '0;
  logic [25:0]        stored_other  = NULL_OTHER;

  mrdp_pkg::out_t pending_chunks[$];
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   n_records      = 0;
  int   n_chunks       = 0;
  int   n_errors       = 0;
  int   cycle_count    = 0;

  move_record_delta_packer_top #(.TRIGGER_COUNT(TRIG_CNT)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Work out the chunk stream for one accepted record and advance the base.
  task automatic predict_chunks(input mrdp_pkg::in_t rec);
    logic [ANG_W-1:0] ang[3];
    logic [ANG_W-1:0] bang[3];
    logic [POS_W-1:0] pos[3];
    logic [POS_W-1:0] bpos[3];
    logic [3*ANG_W-1:0] ref_angles;
    logic [25:0] ref_other;
    logic [15:0] tmask;
    logic [15:0] trig;
    logic [15:0] btrig;
    logic trig_diff;
    logic any_change;
    logic [VAL_W-1:0] vals[MAX_CHUNKS];
    logic [LEN_W-1:0] lens[MAX_CHUNKS];
    int   n;
    mrdp_pkg::out_t c;
    n = 0;
    tmask = 16'((17'd1 << TRIG_CNT) - 17'd1);
    ref_angles = rec.use_base ? stored_angles : '0;
    ref_other  = rec.use_base ? stored_other : NULL_OTHER;
    ang[0] = rec.yaw_code;   ang[1] = rec.pitch_code;  ang[2] = rec.roll_code;
    pos[0] = rec.pos_x_code; pos[1] = rec.pos_y_code;  pos[2] = rec.pos_z_code;
    trig  = 16'(rec.trigger_bits) & tmask;
    btrig = 16'(ref_other[25:20]) & tmask;
    trig_diff = (trig != btrig);
    any_change = trig_diff || (rec.free_look != ref_other[18]) ||
                 (rec.keyboard_mouse != ref_other[19]);
    for (int i = 0; i < 3; i++) begin
      bang[i] = ref_angles[ANG_W*i +: ANG_W];
      bpos[i] = ref_other[POS_W*i +: POS_W];
      if (ang[i] != bang[i] || pos[i] != bpos[i]) any_change = 1'b1;
    end
    if (!rec.use_base) begin
      vals[n] = VAL_W'(any_change); lens[n] = LEN_W'(FLAG_LEN); n++;
    end
    if (rec.use_base || any_change) begin
      for (int i = 0; i < 3; i++) begin
        vals[n] = VAL_W'(ang[i] != bang[i]); lens[n] = LEN_W'(FLAG_LEN); n++;
        if (ang[i] != bang[i]) begin
          vals[n] = VAL_W'(ang[i]); lens[n] = LEN_W'(ANG_W); n++;
        end
      end
      for (int i = 0; i < 3; i++) begin
        vals[n] = VAL_W'(pos[i] != bpos[i]); lens[n] = LEN_W'(FLAG_LEN); n++;
        if (pos[i] != bpos[i]) begin
          vals[n] = VAL_W'(pos[i]); lens[n] = LEN_W'(POS_W); n++;
        end
      end
      vals[n] = VAL_W'(rec.free_look);      lens[n] = LEN_W'(FLAG_LEN); n++;
      vals[n] = VAL_W'(rec.keyboard_mouse); lens[n] = LEN_W'(FLAG_LEN); n++;
      vals[n] = VAL_W'(trig_diff);          lens[n] = LEN_W'(FLAG_LEN); n++;
      if (trig_diff) begin
        for (int i = 0; i < TRIG_CNT; i++) begin
          vals[n] = VAL_W'(trig[i]); lens[n] = LEN_W'(FLAG_LEN); n++;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      c.chunk_value  = vals[k];
      c.chunk_length = lens[k];
      c.last_chunk   = (k == n - 1);
      pending_chunks.push_back(c);
    end
    stored_angles = {ang[2], ang[1], ang[0]};
    stored_other  = {trig[5:0], rec.keyboard_mouse, rec.free_look, pos[2], pos[1], pos[0]};
  endtask

  // Drive random receiver stalls and check every chunk taken.
  always @(posedge clk) begin
    mrdp_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        if (pending_chunks.size() == 0) begin
          $error("unexpected chunk: value %0h length %0d last %0b",
                 out_data.chunk_value, out_data.chunk_length, out_data.last_chunk);
          n_errors++;
        end else begin
          want = pending_chunks.pop_front();
          n_chunks++;
          if (out_data.chunk_value !== want.chunk_value) begin
            $error("chunk_value: expected %0h, got %0h", want.chunk_value,
                   out_data.chunk_value);
            n_errors++;
          end
          if (out_data.chunk_length !== want.chunk_length) begin
            $error("chunk_length: expected %0d, got %0d", want.chunk_length,
                   out_data.chunk_length);
            n_errors++;
          end
          if (out_data.last_chunk !== want.last_chunk) begin
            $error("last_chunk: expected %0b, got %0b", want.last_chunk,
                   out_data.last_chunk);
            n_errors++;
          end
        end
      end
    end
  end

  // Send one record; in_valid stays high on return so back-to-back beats need
  // no extra edge.
  task automatic send_record(input mrdp_pkg::in_t rec);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rec;
    do @(posedge clk); while (in_stall);
    predict_chunks(rec);
    n_records++;
  endtask

  // Hold the input until every expected chunk has drained.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chunks.size() != 0);
  endtask

  function automatic mrdp_pkg::in_t make_record(input logic ub, input logic [ANG_W-1:0] y,
                                      input logic [ANG_W-1:0] p, input logic [ANG_W-1:0] r,
                                      input logic [POS_W-1:0] x, input logic [POS_W-1:0] yy,
                                      input logic [POS_W-1:0] z, input logic fl,
                                      input logic kb, input logic [TRIG_IN_W-1:0] t);
    mrdp_pkg::in_t rec;
    rec.use_base = ub;
    rec.yaw_code = y;    rec.pitch_code = p;  rec.roll_code = r;
    rec.pos_x_code = x;  rec.pos_y_code = yy; rec.pos_z_code = z;
    rec.free_look = fl;  rec.keyboard_mouse = kb;
    rec.trigger_bits = t;
    return rec;
  endfunction

  // Mostly small moves off the stored base; some null records and some noise.
  function automatic mrdp_pkg::in_t next_move();
    mrdp_pkg::in_t rec;
    logic [95:0]   noise;
    rec.use_base       = ($urandom_range(99) < 75);
    rec.yaw_code       = stored_angles[15:0];
    rec.pitch_code     = stored_angles[31:16];
    rec.roll_code      = stored_angles[47:32];
    rec.pos_x_code     = stored_other[5:0];
    rec.pos_y_code     = stored_other[11:6];
    rec.pos_z_code     = stored_other[17:12];
    rec.free_look      = stored_other[18];
    rec.keyboard_mouse = stored_other[19];
    rec.trigger_bits   = stored_other[25:20];
    if ($urandom_range(99) < 10) begin
      noise = {$urandom(), $urandom(), $urandom()};
      rec   = noise[$bits(mrdp_pkg::in_t)-1:0];
    end else if (!rec.use_base && $urandom_range(99) < 20) begin
      rec = make_record(1'b0, '0, '0, '0, NULL_POS, NULL_POS, NULL_POS, 1'b0, 1'b0, '0);
    end else begin
      if ($urandom_range(99) < 40) rec.yaw_code   = ANG_W'($urandom_range(65535));
      if ($urandom_range(99) < 40) rec.pitch_code = ANG_W'($urandom_range(65535));
      if ($urandom_range(99) < 40) rec.roll_code  = ANG_W'($urandom_range(65535));
      if ($urandom_range(99) < 40)
        rec.pos_x_code = POS_W'($urandom_range(99) < 85 ? $urandom_range(32) : $urandom_range(63));
      if ($urandom_range(99) < 40)
        rec.pos_y_code = POS_W'($urandom_range(99) < 85 ? $urandom_range(32) : $urandom_range(63));
      if ($urandom_range(99) < 40)
        rec.pos_z_code = POS_W'($urandom_range(99) < 85 ? $urandom_range(32) : $urandom_range(63));
      if ($urandom_range(99) < 25) rec.free_look      = ~rec.free_look;
      if ($urandom_range(99) < 25) rec.keyboard_mouse = ~rec.keyboard_mouse;
      if ($urandom_range(99) < 35) rec.trigger_bits   = TRIG_IN_W'($urandom_range(63));
    end
    return rec;
  endfunction

  // Null record against null base gives the lone zero flag; then an unchanged
  // record against the stored base gives all-clear presence flags.
  task automatic test_null_record();
    send_record(make_record(1'b0, '0, '0, '0, NULL_POS, NULL_POS, NULL_POS, 1'b0, 1'b0, '0));
    send_record(make_record(1'b1, '0, '0, '0, NULL_POS, NULL_POS, NULL_POS, 1'b0, 1'b0, '0));
    send_record(make_record(1'b0, '0, '0, '0, NULL_POS, NULL_POS, NULL_POS, 1'b0, 1'b0, '0));
  endtask

  // Every field changed: longest chunk streams against null and stored base.
  task automatic test_full_change();
    send_record(make_record(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 6'd0, 6'd32,
                            1'b1, 1'b1, 6'h3F));
    send_record(make_record(1'b1, 16'h0000, 16'h0001, 16'h8000, 6'd0, 6'd32, 6'd63,
                            1'b0, 1'b0, 6'h00));
  endtask

  task automatic test_field_extremes();
    send_record(make_record(1'b1, 16'h0000, 16'hFFFF, 16'h8000, 6'd32, 6'd32, 6'd0,
                            1'b0, 1'b0, 6'h00));
    send_record(make_record(1'b1, 16'h7FFF, 16'hFFFF, 16'h0001, 6'd32, 6'd0, 6'd0,
                            1'b0, 1'b0, 6'h00));
    send_record(make_record(1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd16, 6'd16, 6'd17,
                            1'b0, 1'b0, 6'h00));
  endtask

  // Positions above 32 pass through as raw 6-bit codes.
  task automatic test_out_of_range_positions();
    send_record(make_record(1'b1, '0, '0, '0, 6'd33, 6'd48, 6'd63, 1'b0, 1'b0, 6'h00));
    send_record(make_record(1'b0, '0, '0, '0, 6'd63, 6'd33, 6'd40, 1'b0, 1'b0, 6'h00));
    send_record(make_record(1'b1, '0, '0, '0, 6'd63, 6'd33, 6'd40, 1'b0, 1'b0, 6'h00));
  endtask

  task automatic test_mode_flags_and_triggers();
    send_record(make_record(1'b1, '0, '0, '0, 6'd16, 6'd16, 6'd16, 1'b1, 1'b0, 6'h00));
    send_record(make_record(1'b1, '0, '0, '0, 6'd16, 6'd16, 6'd16, 1'b0, 1'b1, 6'h00));
    send_record(make_record(1'b1, '0, '0, '0, 6'd16, 6'd16, 6'd16, 1'b0, 1'b1, 6'h2A));
    send_record(make_record(1'b1, '0, '0, '0, 6'd16, 6'd16, 6'd16, 1'b0, 1'b1, 6'h15));
    send_record(make_record(1'b1, '0, '0, '0, 6'd16, 6'd16, 6'd16, 1'b0, 1'b1, 6'h15));
    send_record(make_record(1'b0, '0, '0, '0, 6'd16, 6'd16, 6'd16, 1'b0, 1'b0, 6'h01));
    send_record(make_record(1'b0, '0, '0, '0, 6'd16, 6'd16, 6'd16, 1'b0, 1'b0, 6'h20));
  endtask

  task automatic test_random_moves(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_record(next_move());
      // Let the pipeline empty completely now and then.
      if ($urandom_range(99) < 3) pause_until_drained();
    end
  endtask

  task automatic test_drain_pause();
    send_record(next_move());
    send_record(next_move());
    pause_until_drained();
    send_record(next_move());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_null_record();
    test_full_change();
    test_field_extremes();
    test_out_of_range_positions();
    test_mode_flags_and_triggers();
    test_drain_pause();

    test_random_moves(0, 0, 60);
    test_random_moves(73, 0, 60);
    test_random_moves(0, 73, 60);
    test_random_moves(37, 37, 60);

    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_chunks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Packed %0d move records into %0d checked chunks over four idle/stall mixes,",
             n_records, n_chunks);
    $display("with directed null, full-change, extreme and trigger records up front.");
    if (n_errors == 0 && pending_chunks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
